// ===== rtl/tles_pkg.sv =====
package tles_pkg;

    localparam int MAX_ITEMS    = 256;
    localparam int VALUE_BITS   = 24;
    localparam int FIELD_BITS   = 24;
    localparam int IDX_BITS     = $clog2(MAX_ITEMS);
    localparam int CNT_BITS     = $clog2(MAX_ITEMS + 1);
    localparam int CFG_BITS     = 9;
    localparam int CFG_IDX_BITS = 2;
    localparam int CMP_BITS     = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
    localparam int SUM_BITS     = 32;
    localparam int OUT_IDX_BITS = 8;
    localparam int OUT_CNT_BITS = 9;

    localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_SELECT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRONT_COUNT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAIL_COUNT     = 2'd2;

    localparam logic [1:0] CHAN_B = 2'd1;
    localparam logic [1:0] CHAN_C = 2'd2;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [IDX_BITS-1:0]   idx;
        logic [CNT_BITS-1:0]   count;
        logic                  keep;
        logic                  drop;
        logic                  head_add;
        logic                  tail_add;
        logic                  tail_sub;
        logic                  last;
    } tles_item_t;

endpackage

// ===== rtl/tles_ram.sv =====
module tles_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tles_intake.sv =====
module tles_intake (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tles_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [tles_pkg::CFG_BITS-1:0]    cfg_data,
    input  logic                             in_valid,
    input  logic [tles_pkg::FIELD_BITS-1:0]  value_a,
    input  logic [tles_pkg::FIELD_BITS-1:0]  value_b,
    input  logic [tles_pkg::FIELD_BITS-1:0]  value_c,
    input  logic                             last,
    input  logic                             hold,
    output logic                             wr_en,
    output logic [tles_pkg::IDX_BITS-1:0]    wr_addr,
    output logic [tles_pkg::VALUE_BITS-1:0]  wr_data,
    output logic                             rd_en,
    output logic [tles_pkg::IDX_BITS-1:0]    rd_addr,
    output logic                             item_valid,
    output tles_pkg::tles_item_t             item
);
    import tles_pkg::*;

    logic [1:0]          channel_reg;
    logic [CFG_BITS-1:0] front_reg;
    logic [CFG_BITS-1:0] tail_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                item_valid_reg;
    logic                item_valid_next;
    tles_item_t          item_reg;
    tles_item_t          item_next;
    logic                accept;
    logic [FIELD_BITS-1:0] value_sel;
    logic [CMP_BITS-1:0] count_ext;
    logic [CMP_BITS-1:0] front_ext;
    logic [CMP_BITS-1:0] tail_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg <= '0;
            front_reg   <= '0;
            tail_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHANNEL_SELECT: channel_reg <= cfg_data[1:0];
                REG_FRONT_COUNT:    front_reg   <= cfg_data;
                REG_TAIL_COUNT:     tail_reg    <= cfg_data;
                default:            channel_reg <= channel_reg;
            endcase
        end
    end

    assign accept    = in_valid && !hold;
    assign count_ext = CMP_BITS'(count_reg);
    assign front_ext = CMP_BITS'(front_reg);
    assign tail_ext  = CMP_BITS'(tail_reg);

    always_comb
    begin
        unique case (channel_reg)
            CHAN_B:  value_sel = value_b;
            CHAN_C:  value_sel = value_c;
            default: value_sel = value_a;
        endcase

        item_next.value    = VALUE_BITS'(value_sel);
        item_next.idx      = count_reg[IDX_BITS-1:0];
        item_next.keep     = count_reg < CNT_BITS'(MAX_ITEMS);
        item_next.drop     = !item_next.keep;
        item_next.head_add = item_next.keep && (count_ext < front_ext);
        item_next.tail_add = item_next.keep && (tail_reg != '0);
        item_next.tail_sub = item_next.tail_add && (count_ext >= tail_ext);
        item_next.last     = last;
        item_next.count    = item_next.keep ? count_reg + CNT_BITS'(1) : count_reg;

        count_next      = count_reg;
        item_valid_next = item_valid_reg;
        if (!hold)
        begin
            item_valid_next = accept;
        end
        if (accept)
        begin
            count_next = last ? '0 : item_next.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign wr_en      = accept && item_next.keep;
    assign wr_addr    = item_next.idx;
    assign wr_data    = item_next.value;
    assign rd_en      = accept && item_next.tail_sub;
    assign rd_addr    = IDX_BITS'(count_ext - tail_ext);
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/tles_stats.sv =====
module tles_stats (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  tles_pkg::tles_item_t              item,
    input  logic [tles_pkg::VALUE_BITS-1:0]   rd_data,
    input  logic                              out_stall,
    output logic                              hold,
    output logic                              out_valid,
    output logic [tles_pkg::OUT_IDX_BITS-1:0] max_index,
    output logic [tles_pkg::OUT_IDX_BITS-1:0] min_index,
    output logic [tles_pkg::SUM_BITS-1:0]     head_sum,
    output logic [tles_pkg::SUM_BITS-1:0]     tail_sum,
    output logic [tles_pkg::OUT_CNT_BITS-1:0] item_count,
    output logic                              overflow
);
    import tles_pkg::*;

    logic [VALUE_BITS-1:0] best_high_reg, best_high_next;
    logic [IDX_BITS-1:0]   best_high_idx_reg, best_high_idx_next;
    logic [VALUE_BITS-1:0] best_low_reg, best_low_next;
    logic [IDX_BITS-1:0]   best_low_idx_reg, best_low_idx_next;
    logic [SUM_BITS-1:0]   head_total_reg, head_total_next;
    logic [SUM_BITS-1:0]   window_total_reg, window_total_next;
    logic                  dropped_reg, dropped_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_IDX_BITS-1:0] max_index_reg, min_index_reg;
    logic [SUM_BITS-1:0]   head_sum_reg, tail_sum_reg;
    logic [OUT_CNT_BITS-1:0] item_count_reg;
    logic                  overflow_reg;
    logic                  adv;
    logic                  load;
    logic [SUM_BITS-1:0]   v_sum;
    logic [SUM_BITS-1:0]   add_term;
    logic [SUM_BITS-1:0]   sub_term;

    assign hold  = item_valid && item.last && out_valid_reg && out_stall;
    assign adv   = item_valid && !hold;
    assign load  = adv && item.last;
    assign v_sum = SUM_BITS'(item.value);
    assign add_term = item.tail_add ? v_sum : '0;
    assign sub_term = item.tail_sub ? SUM_BITS'(rd_data) : '0;

    always_comb
    begin
        best_high_next     = best_high_reg;
        best_high_idx_next = best_high_idx_reg;
        best_low_next      = best_low_reg;
        best_low_idx_next  = best_low_idx_reg;
        head_total_next    = head_total_reg;
        window_total_next  = window_total_reg;
        dropped_next       = dropped_reg;
        if (adv)
        begin
            if (item.keep)
            begin
                if (item.value > best_high_reg)
                begin
                    best_high_next     = item.value;
                    best_high_idx_next = item.idx;
                end
                if ((item.idx == '0) || (item.value < best_low_reg))
                begin
                    best_low_next     = item.value;
                    best_low_idx_next = item.idx;
                end
                if (item.head_add)
                begin
                    head_total_next = head_total_reg + v_sum;
                end
                window_total_next = window_total_reg + add_term - sub_term;
            end
            dropped_next = dropped_reg || item.drop;
        end

        out_valid_next = load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_high_reg     <= '0;
            best_high_idx_reg <= '0;
            best_low_reg      <= '0;
            best_low_idx_reg  <= '0;
            head_total_reg    <= '0;
            window_total_reg  <= '0;
            dropped_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                best_high_reg     <= '0;
                best_high_idx_reg <= '0;
                best_low_reg      <= '0;
                best_low_idx_reg  <= '0;
                head_total_reg    <= '0;
                window_total_reg  <= '0;
                dropped_reg       <= 1'b0;
            end
            else
            begin
                best_high_reg     <= best_high_next;
                best_high_idx_reg <= best_high_idx_next;
                best_low_reg      <= best_low_next;
                best_low_idx_reg  <= best_low_idx_next;
                head_total_reg    <= head_total_next;
                window_total_reg  <= window_total_next;
                dropped_reg       <= dropped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            max_index_reg  <= OUT_IDX_BITS'(best_high_idx_next);
            min_index_reg  <= OUT_IDX_BITS'(best_low_idx_next);
            head_sum_reg   <= head_total_next;
            tail_sum_reg   <= window_total_next;
            item_count_reg <= OUT_CNT_BITS'(item.count);
            overflow_reg   <= dropped_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign max_index  = max_index_reg;
    assign min_index  = min_index_reg;
    assign head_sum   = head_sum_reg;
    assign tail_sum   = tail_sum_reg;
    assign item_count = item_count_reg;
    assign overflow   = overflow_reg;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (best_high_reg == '0) && (head_total_reg == '0)
                 && (window_total_reg == '0) && !dropped_reg)
        else $error("list state not cleared after final item");

    a_hold_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> item_valid && $stable(item) && $stable(rd_data))
        else $error("update stage lost its item while held");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(load))
        else $error("result appeared without a final item");

endmodule

// ===== rtl/triple_list_extrema_and_end_sums.sv =====
// Running argmax/argmin, head sum and tail sum over a stream of value triples. One item is
// transferred per cycle unless stalled; its result (only for an item with last set) passes the
// intake item register, then the output register. The rate is set by the ring buffer RAM,
// which writes the new value and reads the one leaving the tail window in the same cycle on
// separate ports; the update stage uses the registered read data. The input stalls only while
// a finished result waits to be taken and another final item has reached the update stage.
// Lists longer than the store depth drop the extra items and flag overflow.
module triple_list_extrema_and_end_sums (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tles_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tles_pkg::CFG_BITS-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [tles_pkg::FIELD_BITS-1:0]    value_a,
    input  logic [tles_pkg::FIELD_BITS-1:0]    value_b,
    input  logic [tles_pkg::FIELD_BITS-1:0]    value_c,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tles_pkg::OUT_IDX_BITS-1:0]  max_index,
    output logic [tles_pkg::OUT_IDX_BITS-1:0]  min_index,
    output logic [tles_pkg::SUM_BITS-1:0]      head_sum,
    output logic [tles_pkg::SUM_BITS-1:0]      tail_sum,
    output logic [tles_pkg::OUT_CNT_BITS-1:0]  item_count,
    output logic                               overflow
);
    import tles_pkg::*;

    logic                  hold;
    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [IDX_BITS-1:0]   rd_addr;
    logic [VALUE_BITS-1:0] rd_data;
    logic                  item_valid;
    tles_item_t            item;

    tles_intake u_intake (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .value_a    (value_a),
        .value_b    (value_b),
        .value_c    (value_c),
        .last       (last),
        .hold       (hold),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .item_valid (item_valid),
        .item       (item)
    );

    tles_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_window_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tles_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .rd_data    (rd_data),
        .out_stall  (out_stall),
        .hold       (hold),
        .out_valid  (out_valid),
        .max_index  (max_index),
        .min_index  (min_index),
        .head_sum   (head_sum),
        .tail_sum   (tail_sum),
        .item_count (item_count),
        .overflow   (overflow)
    );

    assign in_stall = hold;

endmodule
